// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants for the segment cover counter
// Request codes, the control word that travels with an item down the cell
// chain, and the default sizes of the segment store and the coordinates.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned MAX_SEGMENTS = 256;
  localparam int unsigned COORD_BITS   = 32;
  localparam int unsigned IN_COORD_W   = 32;
  localparam int unsigned CNT_W        = 9;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef struct packed {
    logic vld;
    req_e kind;
  } tok_ctrl_t;

endpackage

// ===== hw/rtl/scc_cell.sv =====
// ----------------------------------------------------------------------------
// scc_cell: one slot of the segment store
// Holds one segment and passes the item stream to its right neighbor every
// cycle: a load fills the first empty slot, a clear empties each slot it
// passes, and a query adds this slot's hit to the running count.
// ----------------------------------------------------------------------------
module scc_cell import scc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tok_ctrl_t                   ctrl_i,
  input  logic signed [CoordBits-1:0] a_i,
  input  logic signed [CoordBits-1:0] b_i,
  input  logic        [CNT_W-1:0]     cnt_i,
  output tok_ctrl_t                   ctrl_o,
  output logic signed [CoordBits-1:0] a_o,
  output logic signed [CoordBits-1:0] b_o,
  output logic        [CNT_W-1:0]     cnt_o
);

  logic                        occ_q, occ_d;
  logic signed [CoordBits-1:0] low_q, high_q;
  tok_ctrl_t                   ctrl_q, ctrl_d;
  logic signed [CoordBits-1:0] a_q, b_q;
  logic        [CNT_W-1:0]     cnt_q, cnt_d;
  logic                        cap;
  logic                        hit;
  logic        [CNT_W:0]       cnt_sum;

  always_comb begin
    hit     = occ_q && (low_q <= a_i) && (a_i <= high_q);
    cnt_sum = {1'b0, cnt_i} + (CNT_W + 1)'(hit);
    // saturate the running count
    cnt_d   = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
    ctrl_d  = ctrl_i;
    occ_d   = occ_q;
    cap     = 1'b0;
    if (ctrl_i.vld) begin
      unique case (ctrl_i.kind)
        REQ_LOAD: begin
          if (!occ_q) begin
            // take the segment and drop the item from the stream
            occ_d      = 1'b1;
            cap        = 1'b1;
            ctrl_d.vld = 1'b0;
          end
        end
        REQ_CLEAR: begin
          occ_d = 1'b0;
        end
        REQ_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= 1'b0;
      ctrl_q.vld <= 1'b0;
      ctrl_q.kind <= REQ_LOAD;
    end else begin
      occ_q  <= occ_d;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_i;
    b_q   <= b_i;
    cnt_q <= cnt_d;
    if (cap) begin
      low_q  <= a_i;
      high_q <= b_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign cnt_o  = cnt_q;

endmodule

// ===== hw/rtl/segment_cover_counter.sv =====
// ----------------------------------------------------------------------------
// segment_cover_counter: count stored segments that contain a query point
// Items enter an input register and then walk a row of MaxSegments cells, one
// cell a cycle; each cell holds one segment. Overflowing loads set a sticky
// drop flag at the end of the row, which each query result reports.
// ----------------------------------------------------------------------------
// Result path: the input register, the walk through the cell row and the output
// register lie in that order between an accepted item and done_o.
// Throughput: one item per clock cycle; busy_o stays low, results cannot
// be stalled and leave in request order.
// Reset: empties every cell and clears the drop flag; no clearing pass.
// ----------------------------------------------------------------------------
module segment_cover_counter import scc_pkg::*; #(
  parameter int unsigned MaxSegments = MAX_SEGMENTS,
  parameter int unsigned CoordBits   = COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic        [1:0]            req_type_i,
  input  logic signed [IN_COORD_W-1:0] coord_a_i,
  input  logic signed [IN_COORD_W-1:0] coord_b_i,
  output logic                         done_o,
  output logic        [CNT_W-1:0]      cover_count_o,
  output logic                         dropped_o
);

  logic signed [CoordBits-1:0] a_c, b_c;
  tok_ctrl_t                   ent_ctrl_q, ent_ctrl_d;
  logic signed [CoordBits-1:0] ent_a_q, ent_a_d, ent_b_q, ent_b_d;
  logic                        accept;

  tok_ctrl_t                   ctrl_w [MaxSegments+1];
  logic signed [CoordBits-1:0] a_w    [MaxSegments+1];
  logic signed [CoordBits-1:0] b_w    [MaxSegments+1];
  logic        [CNT_W-1:0]     cnt_w  [MaxSegments+1];

  logic             drop_q, drop_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] count_q;
  logic             dropped_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // wrap or sign-extend the input coordinates to the internal width
  if (CoordBits <= IN_COORD_W) begin : g_wrap
    assign a_c = coord_a_i[CoordBits-1:0];
    assign b_c = coord_b_i[CoordBits-1:0];
  end else begin : g_ext
    assign a_c = CoordBits'(coord_a_i);
    assign b_c = CoordBits'(coord_b_i);
  end

  always_comb begin
    ent_ctrl_d.vld  = 1'b0;
    ent_ctrl_d.kind = req_e'(req_type_i);
    ent_a_d         = a_c;
    ent_b_d         = b_c;
    unique case (req_type_i)
      REQ_LOAD: begin
        ent_ctrl_d.vld = accept;
        // store ends in ascending order
        if (a_c > b_c) begin
          ent_a_d = b_c;
          ent_b_d = a_c;
        end
      end
      REQ_QUERY, REQ_CLEAR: begin
        ent_ctrl_d.vld = accept;
      end
      default: begin
        ent_ctrl_d.vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_ctrl_q.vld  <= 1'b0;
      ent_ctrl_q.kind <= REQ_LOAD;
    end else begin
      ent_ctrl_q <= ent_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_a_q <= ent_a_d;
    ent_b_q <= ent_b_d;
  end

  assign ctrl_w[0] = ent_ctrl_q;
  assign a_w[0]    = ent_a_q;
  assign b_w[0]    = ent_b_q;
  assign cnt_w[0]  = '0;

  for (genvar g = 0; g < MaxSegments; g++) begin : g_cell
    scc_cell #(
      .CoordBits(CoordBits)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl_w[g]),
      .a_i   (a_w[g]),
      .b_i   (b_w[g]),
      .cnt_i (cnt_w[g]),
      .ctrl_o(ctrl_w[g+1]),
      .a_o   (a_w[g+1]),
      .b_o   (b_w[g+1]),
      .cnt_o (cnt_w[g+1])
    );
  end

  // a load still in the stream at the end of the row found no empty cell
  always_comb begin
    drop_d = drop_q;
    done_d = 1'b0;
    if (ctrl_w[MaxSegments].vld) begin
      unique case (ctrl_w[MaxSegments].kind)
        REQ_LOAD:  drop_d = 1'b1;
        REQ_QUERY: done_d = 1'b1;
        REQ_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      drop_q <= drop_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q   <= cnt_w[MaxSegments];
    dropped_q <= drop_q;
  end

  assign done_o        = done_q;
  assign cover_count_o = count_q;
  assign dropped_o     = dropped_q;

  a_done_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(ctrl_w[MaxSegments].vld)
                && $past(ctrl_w[MaxSegments].kind) == REQ_QUERY))
    else $error("result strobe without a query at the end of the row");

  a_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |=> drop_q)
    else $error("drop flag cleared outside reset");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(cover_count_o) <= MaxSegments))
    else $error("cover count exceeds the number of cells");

endmodule

// ===== tb/segment_cover_counter_test.sv =====
// ----------------------------------------------------------------------------
// segment_cover_counter_test: self-checking bench for the segment cover counter
// Drives load, query, clear and unused items with random idle gaps, tracks the segment
// store in the bench, and checks every query result in order as it strobes out.
// ----------------------------------------------------------------------------
module segment_cover_counter_test;
  import scc_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         LATENCY     = MAX_SEGMENTS + 2;
  localparam int         DRAIN_LIMIT = 10 * LATENCY;
  localparam int         RUN_LIMIT   = 1_500_000;

  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic             dropped;
  } cover_result_t;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         start_i       = 1'b0;
  logic        [1:0]            req_type_i    = REQ_LOAD;
  logic signed [IN_COORD_W-1:0] coord_a_i     = '0;
  logic signed [IN_COORD_W-1:0] coord_b_i     = '0;
  logic                         busy_o;
  logic                         done_o;
  logic        [CNT_W-1:0]      cover_count_o;
  logic                         dropped_o;

  // Bench copy of the segment store
  logic signed [IN_COORD_W-1:0] seg_lo [MAX_SEGMENTS];
  logic signed [IN_COORD_W-1:0] seg_hi [MAX_SEGMENTS];
  int                           seg_cnt    = 0;
  logic                         drop_seen  = 1'b0;

  cover_result_t cover_q [$];
  int            errors     = 0;
  int            items_sent = 0;
  bit            no_idle    = 1'b0;

  segment_cover_counter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .coord_a_i    (coord_a_i),
    .coord_b_i    (coord_b_i),
    .done_o       (done_o),
    .cover_count_o(cover_count_o),
    .dropped_o    (dropped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("%0t: timeout, %0d results still pending", $time, cover_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Update the store for one accepted item and queue the query answer
  function automatic void track_request(logic [1:0] kind, logic [31:0] a, logic [31:0] b);
    logic signed [IN_COORD_W-1:0] pa;
    logic signed [IN_COORD_W-1:0] pb;
    int                           hits;
    cover_result_t                res;
    pa   = a;
    pb   = b;
    hits = 0;
    case (kind)
      REQ_LOAD: begin
        if (seg_cnt < int'(MAX_SEGMENTS)) begin
          seg_lo[seg_cnt] = (pa > pb) ? pb : pa;
          seg_hi[seg_cnt] = (pa > pb) ? pa : pb;
          seg_cnt++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      REQ_QUERY: begin
        for (int i = 0; i < seg_cnt; i++) begin
          if (seg_lo[i] <= pa && pa <= seg_hi[i]) hits++;
        end
        if (hits > int'(CNT_MAX)) hits = int'(CNT_MAX);
        res.hits    = hits[CNT_W-1:0];
        res.dropped = drop_seen;
        cover_q.push_back(res);
      end
      REQ_CLEAR: seg_cnt = 0;
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  task automatic send_item(logic [1:0] kind, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= kind;
    coord_a_i  <= a;
    coord_b_i  <= b;
    do @(posedge clk_i); while (busy_o);
    track_request(kind, a, b);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'h8000_0000 + 32'd20;
      2:       return 32'h7fff_ffff - 32'd20;
      default: return $urandom();
    endcase
  endfunction

  // Mostly cluster around the base so segments overlap and queries hit
  function automatic logic [31:0] near_coord(logic [31:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return base + 32'($urandom_range(0, 64)) - 32'd32;
    if (r == 7) return base + 32'($urandom_range(0, 4096)) - 32'd2048;
    if (r == 8) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h8000_0001;
      2:       return 32'h7fff_fffe;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic send_noise();
    logic [1:0] kind;
    kind = 2'($urandom_range(0, 3));
    if (kind == REQ_LOAD && seg_cnt >= int'(MAX_SEGMENTS) - 6) kind = REQ_QUERY;
    send_item(kind, $urandom(), $urandom());
  endtask

  task automatic test_empty_store();
    send_item(REQ_QUERY, 32'd0, $urandom());
    send_item(REQ_QUERY, 32'h8000_0000, 32'h7fff_ffff);
    send_item(REQ_QUERY, 32'h7fff_ffff, 32'h8000_0000);
  endtask

  task automatic test_directed_segments();
    send_item(REQ_LOAD, 32'h8000_0000, 32'h7fff_ffff);
    // reversed ends must be swapped
    send_item(REQ_LOAD, 32'd10, -32'sd10);
    send_item(REQ_LOAD, 32'd5, 32'd5);
    // unknown type must leave the store alone
    send_item(REQ_UNUSED, 32'd0, 32'd0);
    send_item(REQ_QUERY, 32'h8000_0000, $urandom());
    send_item(REQ_QUERY, 32'h7fff_ffff, $urandom());
    send_item(REQ_QUERY, -32'sd10, $urandom());
    send_item(REQ_QUERY, 32'd10, $urandom());
    send_item(REQ_QUERY, 32'd11, $urandom());
    send_item(REQ_QUERY, -32'sd11, $urandom());
    send_item(REQ_QUERY, 32'd5, $urandom());
    send_item(REQ_QUERY, 32'd0, $urandom());
    send_item(REQ_CLEAR, $urandom(), $urandom());
    send_item(REQ_QUERY, 32'd0, $urandom());
  endtask

  task automatic test_random_traffic(int n_items);
    int          first;
    int          n_load;
    int          n_query;
    logic [31:0] base;
    first = items_sent;
    while (items_sent - first < n_items) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (seg_cnt > 180 || $urandom_range(0, 3) != 0)
        send_item(REQ_CLEAR, $urandom(), $urandom());
      base   = pick_base();
      n_load = $urandom_range(1, 40);
      for (int i = 0; i < n_load; i++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else if (seg_cnt < int'(MAX_SEGMENTS) - 6)
          send_item(REQ_LOAD, near_coord(base), near_coord(base));
      end
      n_query = $urandom_range(1, 30);
      for (int i = 0; i < n_query; i++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_item(REQ_QUERY, near_coord(base), $urandom());
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_store_overflow();
    int k;
    send_item(REQ_CLEAR, $urandom(), $urandom());
    // every segment covers zero, so a query at zero sees a full count
    for (int i = 0; i < int'(MAX_SEGMENTS); i++) begin
      k = $urandom_range(0, 1000);
      if ($urandom_range(0, 1)) send_item(REQ_LOAD, -k, k);
      else send_item(REQ_LOAD, k, -k);
    end
    send_item(REQ_QUERY, 32'd0, $urandom());
    send_item(REQ_QUERY, 32'h8000_0000, $urandom());
    send_item(REQ_QUERY, 32'd500, $urandom());
    for (int i = 0; i < 3; i++) send_item(REQ_LOAD, $urandom(), $urandom());
    send_item(REQ_QUERY, 32'd0, $urandom());
    send_item(REQ_CLEAR, $urandom(), $urandom());
    send_item(REQ_QUERY, 32'd0, $urandom());
    send_item(REQ_LOAD, -32'sd3, 32'd3);
    send_item(REQ_QUERY, 32'd3, $urandom());
  endtask

  always @(posedge clk_i) begin
    cover_result_t want;
    if (rst_ni && done_o) begin
      if (cover_q.size() == 0) begin
        $display("%0t: result with none expected: count %0d dropped %0b",
                 $time, cover_count_o, dropped_o);
        errors++;
      end else begin
        want = cover_q.pop_front();
        if (cover_count_o !== want.hits) begin
          $display("%0t: cover_count expected %0d actual %0d",
                   $time, want.hits, cover_count_o);
          errors++;
        end
        if (dropped_o !== want.dropped) begin
          $display("%0t: dropped expected %0b actual %0b",
                   $time, want.dropped, dropped_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_directed_segments();
    test_random_traffic(1200);
    test_store_overflow();
    test_random_traffic(150);

    start_i <= 1'b0;
    guard = 0;
    while (cover_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    // catch any stray result after the last expected one
    repeat (LATENCY + 8) @(posedge clk_i);
    if (cover_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, cover_q.size());
    if (errors == 0 && cover_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/scc_pkg.sv
hw/rtl/scc_cell.sv
hw/rtl/segment_cover_counter.sv
tb/segment_cover_counter_test.sv
